// File: rtl/nvs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nvs_pkg
// Shared types and constants of the nearest vertex search unit.
// ============================================================================
package nvs_pkg;

    localparam int MAX_TARGETS = 1024;
    localparam int COORD_BITS  = 16;
    localparam int IDX_BITS    = $clog2(MAX_TARGETS);
    localparam int CNT_BITS    = $clog2(MAX_TARGETS + 1);
    localparam int VTX_BITS    = 3 * COORD_BITS;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int DIST_BITS   = SQ_BITS + 2;
    localparam int OUT_FIELDS  = VTX_BITS + 10;
    localparam int OUT_BITS    = ((OUT_FIELDS + 7) / 8) * 8;
    localparam int IN_BITS     = ((VTX_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_ANSWERED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic scan_issue;
        logic load_out;
    } t_nvs_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_nvs_sts;

endpackage

// File: rtl/nvs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// nvs_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module nvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/nvs_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// nvs_datapath
// Target store, scan counter, distance pipeline, running minimum and the
// output register.
// ============================================================================
module nvs_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  i_cfg_wr_data,
    input  nvs_pkg::t_nvs_cmd                     i_cmd,
    input  logic [nvs_pkg::VTX_BITS-1:0]          i_vertex,
    input  logic                                  i_m_ready,
    output nvs_pkg::t_nvs_sts                     o_sts,
    output logic                                  o_m_valid,
    output logic [nvs_pkg::OUT_BITS-1:0]          o_m_data,
    output logic [1:0]                            o_m_status
);

    localparam int CB = nvs_pkg::COORD_BITS;

    function automatic logic [CB-1:0] f_abs_diff(input logic [CB-1:0] a,
                                                 input logic [CB-1:0] b);
        logic [CB:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        if (d[CB]) begin
            d = -d;
        end
        return d[CB-1:0];
    endfunction

    logic                               r_dim_mode;
    logic [nvs_pkg::CNT_BITS-1:0]       r_count;
    logic [nvs_pkg::IDX_BITS-1:0]       r_scan_idx;
    logic [nvs_pkg::VTX_BITS-1:0]       r_src;
    nvs_pkg::t_status                   r_pend_status;

    logic                               w_full;
    logic                               w_wr_en;
    logic [nvs_pkg::VTX_BITS-1:0]       w_rd_data;

    logic                               r_v1, r_v2, r_v3, r_v4;
    logic [nvs_pkg::IDX_BITS-1:0]       r_i1, r_i2, r_i3, r_i4;
    logic [nvs_pkg::VTX_BITS-1:0]       r_c2, r_c3, r_c4;
    logic [CB-1:0]                      r_dx, r_dy, r_dz;
    logic [nvs_pkg::SQ_BITS-1:0]        r_sx, r_sy, r_sz;
    logic [nvs_pkg::DIST_BITS-1:0]      r_dist;

    logic                               r_best_vld;
    logic [nvs_pkg::DIST_BITS-1:0]      r_best_dist;
    logic [nvs_pkg::IDX_BITS-1:0]       r_best_idx;
    logic [nvs_pkg::VTX_BITS-1:0]       r_best_c;

    logic                               r_out_vld;
    nvs_pkg::t_status                   r_out_status;
    logic [nvs_pkg::IDX_BITS-1:0]       r_out_idx;
    logic [nvs_pkg::VTX_BITS-1:0]       r_out_c;

    assign w_full  = (r_count == nvs_pkg::CNT_BITS'(nvs_pkg::MAX_TARGETS));
    assign w_wr_en = i_cmd.accept && (i_cmd.op == nvs_pkg::OP_APPEND) && !w_full;

    nvs_ram #(
        .WIDTH (nvs_pkg::VTX_BITS),
        .DEPTH (nvs_pkg::MAX_TARGETS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[nvs_pkg::IDX_BITS-1:0]),
        .i_wr_data (i_vertex),
        .i_rd_en   (i_cmd.scan_issue),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_dim_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && i_cmd.op == nvs_pkg::OP_CLEAR) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src <= i_vertex;
            case (i_cmd.op)
                nvs_pkg::OP_APPEND: begin
                    r_pend_status <= w_full ? nvs_pkg::ST_FULL : nvs_pkg::ST_ACCEPTED;
                end
                nvs_pkg::OP_QUERY: begin
                    r_pend_status <= (r_count == '0) ? nvs_pkg::ST_EMPTY
                                                     : nvs_pkg::ST_ANSWERED;
                end
                default: begin
                    r_pend_status <= nvs_pkg::ST_ACCEPTED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_scan_idx;
        r_i2 <= r_i1;
        r_c2 <= w_rd_data;
        r_dx <= f_abs_diff(r_src[CB-1:0], w_rd_data[CB-1:0]);
        r_dy <= f_abs_diff(r_src[2*CB-1:CB], w_rd_data[2*CB-1:CB]);
        r_dz <= r_dim_mode ? f_abs_diff(r_src[3*CB-1:2*CB], w_rd_data[3*CB-1:2*CB])
                           : '0;
        r_i3 <= r_i2;
        r_c3 <= r_c2;
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
        r_sz <= r_dz * r_dz;
        r_i4 <= r_i3;
        r_c4 <= r_c3;
        r_dist <= {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_best_vld <= 1'b0;
        end else if (r_v4) begin
            r_best_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && (!r_best_vld || r_dist < r_best_dist)) begin
            r_best_dist <= r_dist;
            r_best_idx  <= r_i4;
            r_best_c    <= r_c4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_pend_status;
            if (r_pend_status == nvs_pkg::ST_ANSWERED) begin
                r_out_idx <= r_best_idx;
                r_out_c   <= {r_dim_mode ? r_best_c[3*CB-1:2*CB] : {CB{1'b0}},
                              r_best_c[2*CB-1:0]};
            end else begin
                r_out_idx <= '0;
                r_out_c   <= '0;
            end
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.last_issue = ({1'b0, r_scan_idx} == nvs_pkg::CNT_BITS'(r_count - 1'b1));
    assign o_sts.pipe_busy  = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.out_free   = !r_out_vld || i_m_ready;

    assign o_m_valid  = r_out_vld;
    assign o_m_status = r_out_status;
    assign o_m_data   = {{(nvs_pkg::OUT_BITS - nvs_pkg::OUT_FIELDS){1'b0}},
                         r_out_idx, r_out_c};

endmodule

// File: rtl/nvs_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// nvs_ctrl
// Sequencer for the input handshake, the target scan and the response.
// ============================================================================
module nvs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic [1:0]         i_s_op,
    input  nvs_pkg::t_nvs_sts  i_sts,
    output logic               o_s_ready,
    output nvs_pkg::t_nvs_cmd  o_cmd
);

    nvs_pkg::t_state r_state;
    nvs_pkg::t_state n_state;
    nvs_pkg::t_op    w_op;

    assign w_op = nvs_pkg::t_op'(i_s_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nvs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_s_ready        = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.op         = w_op;
        o_cmd.scan_issue = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            nvs_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    if (w_op == nvs_pkg::OP_QUERY && !i_sts.count_zero) begin
                        n_state = nvs_pkg::S_SCAN;
                    end else begin
                        n_state = nvs_pkg::S_RESP;
                    end
                end
            end
            nvs_pkg::S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = nvs_pkg::S_DRAIN;
                end
            end
            nvs_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = nvs_pkg::S_RESP;
                end
            end
            nvs_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = nvs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nvs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/nearest_vertex_search_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// nearest_vertex_search_unit
// Brute-force nearest neighbor search over a store of up to 1024 vertices.
// ============================================================================
// Each input beat carries an opcode on s_axis_tuser and a vertex on
// s_axis_tdata: clear the store, append the vertex, or query with it.
// Every input beat produces exactly one output beat with a status on
// m_axis_tuser and, for an answered query, the closest stored vertex and
// its position on m_axis_tdata; ties go to the earliest position.
// The dimension mode register selects 2D (x, y) or 3D (x, y, z) distance
// and should be written only while the unit is idle.
// Clear, append and unused opcodes go straight to the response, as does
// a query on an empty store. Any other query scans the stored vertices,
// reading one per cycle from the store memory into the distance pipeline.
// Results sit in an output register, so a stalled receiver holds the
// output beat steady; the unit finishes its current item and then waits
// with s_axis_tready low. Reset empties the store and selects 2D mode;
// memory contents are not cleared and need no sweep.
// ============================================================================
module nearest_vertex_search_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    input  logic [nvs_pkg::IN_BITS-1:0]     s_axis_tdata,
    // op [1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // near_x [15:0], near_y [31:16], near_z [47:32], near_index [57:48], zeros above
    output logic [nvs_pkg::OUT_BITS-1:0]    m_axis_tdata,
    // status [1:0]
    output logic [1:0]                      m_axis_tuser
);

    nvs_pkg::t_nvs_cmd w_cmd;
    nvs_pkg::t_nvs_sts w_sts;

    nvs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_op    (s_axis_tuser),
        .i_sts     (w_sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    nvs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .i_vertex      (s_axis_tdata[nvs_pkg::VTX_BITS-1:0]),
        .i_m_ready     (m_axis_tready),
        .o_sts         (w_sts),
        .o_m_valid     (m_axis_tvalid),
        .o_m_data      (m_axis_tdata),
        .o_m_status    (m_axis_tuser)
    );

endmodule

// File: test/nearest_vertex_search_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// nearest_vertex_search_unit_tb
// Self-checking bench for the brute-force nearest vertex search unit.
// ============================================================================
// A directed table covers the empty store, coordinate extremes, ties, the
// unused opcode, clears and 3D distance. Random phases follow with different
// idling on both streams and both dimension modes. Every output beat is
// checked against a result from the table or a predictor tracking the store.
// ============================================================================
module nearest_vertex_search_unit_tb;
    import nvs_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 70;
    localparam int SOFT_FILL = 48;
    localparam logic [15:0] COORD_MIN = 16'h8000;
    localparam logic [15:0] COORD_MAX = 16'h7FFF;

    typedef struct packed {
        t_status     status;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [9:0]  nidx;
    } search_result_t;

    typedef struct {
        int             set_dim;
        t_op            op;
        logic [15:0]    x;
        logic [15:0]    y;
        logic [15:0]    z;
        bit             typed;
        search_result_t res;
    } stim_row_t;

    localparam search_result_t R_ACC   = '{ST_ACCEPTED, 16'd0, 16'd0, 16'd0, 10'd0};
    localparam search_result_t R_EMPTY = '{ST_EMPTY, 16'd0, 16'd0, 16'd0, 10'd0};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic                i_cfg_wr_data = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = OP_NOP;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    logic [15:0]    tgt_x [MAX_TARGETS];
    logic [15:0]    tgt_y [MAX_TARGETS];
    logic [15:0]    tgt_z [MAX_TARGETS];
    int             tgt_count = 0;
    bit             dim3_mode = 1'b0;
    search_result_t pending_results [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    stim_row_t dir_tbl [23] = '{
        '{-1, OP_QUERY,  16'd0, 16'd0, 16'd0, 1'b1, R_EMPTY},
        '{-1, OP_NOP,    COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, R_ACC},
        '{-1, OP_APPEND, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, R_ACC},
        '{-1, OP_APPEND, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, R_ACC},
        '{-1, OP_QUERY,  COORD_MAX, COORD_MAX, COORD_MIN, 1'b1,
          '{ST_ANSWERED, COORD_MAX, COORD_MAX, 16'd0, 10'd1}},
        '{-1, OP_QUERY,  COORD_MIN, COORD_MIN, COORD_MAX, 1'b1,
          '{ST_ANSWERED, COORD_MIN, COORD_MIN, 16'd0, 10'd0}},
        '{-1, OP_APPEND, COORD_MAX, COORD_MAX, 16'd0, 1'b1, R_ACC},
        '{-1, OP_QUERY,  16'd30000, 16'd30000, 16'd0, 1'b0, R_ACC},
        '{-1, OP_QUERY,  16'd0, 16'd0, 16'd0, 1'b0, R_ACC},
        '{-1, OP_CLEAR,  16'd0, 16'd0, 16'd0, 1'b1, R_ACC},
        '{-1, OP_QUERY,  16'd5, 16'd5, 16'd5, 1'b1, R_EMPTY},
        '{-1, OP_APPEND, 16'd16, 16'hFFF0, 16'd5, 1'b1, R_ACC},
        '{-1, OP_APPEND, 16'hFFFF, 16'd1, 16'hFFFB, 1'b1, R_ACC},
        '{-1, OP_QUERY,  16'd0, 16'd0, 16'd100, 1'b0, R_ACC},
        '{-1, OP_NOP,    16'd0, 16'd0, 16'd0, 1'b1, R_ACC},
        '{-1, OP_QUERY,  16'd8, 16'hFFF8, 16'd0, 1'b0, R_ACC},
        '{-1, OP_CLEAR,  16'd0, 16'd0, 16'd0, 1'b1, R_ACC},
        '{-1, OP_CLEAR,  16'd0, 16'd0, 16'd0, 1'b1, R_ACC},
        '{1,  OP_APPEND, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, R_ACC},
        '{-1, OP_APPEND, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, R_ACC},
        '{-1, OP_QUERY,  COORD_MIN, COORD_MIN, COORD_MAX, 1'b1,
          '{ST_ANSWERED, COORD_MIN, COORD_MIN, COORD_MAX, 10'd1}},
        '{-1, OP_QUERY,  COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, R_ACC},
        '{-1, OP_CLEAR,  16'd0, 16'd0, 16'd0, 1'b1, R_ACC}
    };

    int phase_send [8] = '{0, 67, 0, 35, 0, 67, 0, 35};
    int phase_recv [8] = '{0, 0, 67, 35, 0, 0, 67, 35};
    bit phase_dim  [8] = '{0, 1, 0, 1, 1, 0, 1, 0};

    nearest_vertex_search_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic search_result_t predict_search_result(
        t_op op, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
        search_result_t res;
        longint         best_d;
        longint         d;
        longint         dx;
        longint         dy;
        longint         dz;
        int             best_i;
        res = '0;
        res.status = ST_ACCEPTED;
        case (op)
            OP_CLEAR: tgt_count = 0;
            OP_APPEND: begin
                if (tgt_count >= MAX_TARGETS) begin
                    res.status = ST_FULL;
                end else begin
                    tgt_x[tgt_count] = sx;
                    tgt_y[tgt_count] = sy;
                    tgt_z[tgt_count] = sz;
                    tgt_count++;
                end
            end
            OP_QUERY: begin
                if (tgt_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    best_i = 0;
                    best_d = 0;
                    for (int i = 0; i < tgt_count; i++) begin
                        dx = longint'($signed(sx)) - longint'($signed(tgt_x[i]));
                        dy = longint'($signed(sy)) - longint'($signed(tgt_y[i]));
                        dz = longint'($signed(sz)) - longint'($signed(tgt_z[i]));
                        d = dx * dx + dy * dy + (dim3_mode ? dz * dz : 64'sd0);
                        if (i == 0 || d < best_d) begin
                            best_d = d;
                            best_i = i;
                        end
                    end
                    res.status = ST_ANSWERED;
                    res.nx = tgt_x[best_i];
                    res.ny = tgt_y[best_i];
                    res.nz = dim3_mode ? tgt_z[best_i] : 16'd0;
                    res.nidx = best_i[9:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_vertex_beat(input t_op op, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] z,
                                    input bit typed = 1'b0,
                                    input search_result_t typed_res = '0);
        search_result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_search_result(op, x, y, z);
        pending_results.push_back(typed ? typed_res : pred);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_dimension_mode(input bit mode);
        wait_results_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dim3_mode = mode;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int n_items, input bit hold_midway);
        t_op         op;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        int          pick;
        int          sel;
        for (int n = 0; n < n_items; n++) begin
            if (hold_midway && n == n_items / 2)
                wait_results_drained();
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            pick = $urandom_range(99);
            if (tgt_count >= SOFT_FILL && $urandom_range(3) == 0)
                op = OP_CLEAR;
            else if (pick < 4)
                op = OP_CLEAR;
            else if (pick < 9)
                op = OP_NOP;
            else if (pick < 45)
                op = OP_APPEND;
            else
                op = OP_QUERY;
            if (op == OP_APPEND || op == OP_QUERY) begin
                if (tgt_count > 0 && $urandom_range(3) == 0) begin
                    sel = $urandom_range(tgt_count - 1);
                    x = tgt_x[sel];
                    y = tgt_y[sel];
                    z = tgt_z[sel];
                    if ($urandom_range(1) == 0) begin
                        x = x + 16'(int'($urandom_range(6)) - 3);
                        y = y + 16'(int'($urandom_range(6)) - 3);
                        z = z + 16'(int'($urandom_range(6)) - 3);
                    end
                end
            end
            send_vertex_beat(op, x, y, z);
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_output
        search_result_t got;
        search_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser);
            got.nx = m_axis_tdata[15:0];
            got.ny = m_axis_tdata[31:16];
            got.nz = m_axis_tdata[47:32];
            got.nidx = m_axis_tdata[57:48];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: output beat with no result pending", $time);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch expected status %0d x %0d y %0d z %0d index %0d",
                                 $time, want.status, $signed(want.nx), $signed(want.ny),
                                 $signed(want.nz), want.nidx);
                        $display("    got status %0d x %0d y %0d z %0d index %0d",
                                 got.status, $signed(got.nx), $signed(got.ny),
                                 $signed(got.nz), got.nidx);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < 23; r++) begin
            if (dir_tbl[r].set_dim >= 0)
                write_dimension_mode(dir_tbl[r].set_dim[0]);
            send_vertex_beat(dir_tbl[r].op, dir_tbl[r].x, dir_tbl[r].y, dir_tbl[r].z,
                             dir_tbl[r].typed, dir_tbl[r].res);
        end

        for (int p = 0; p < 8; p++) begin
            write_dimension_mode(phase_dim[p]);
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            run_random_phase(PHASE_ITEMS, p == 3);
        end

        wait_results_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/nvs_pkg.sv
rtl/nvs_ram.sv
rtl/nvs_datapath.sv
rtl/nvs_ctrl.sv
rtl/nearest_vertex_search_unit.sv
test/nearest_vertex_search_unit_tb.sv
